// ===== hw/rtl/nqc_pkg.sv =====
// shared types, constants and helpers for the n-queens solution counter
package nqc_pkg;

  localparam int unsigned MaxSize = 16;
  localparam int unsigned MinSize = 2;
  localparam int unsigned ResetSize = 8;
  localparam int unsigned SizeW = 5;
  localparam int unsigned RowW = $clog2(MaxSize);
  localparam int unsigned CandW = $clog2(MaxSize + 1);
  localparam int unsigned MarkW = 2 * MaxSize - 1;
  localparam int unsigned MarkIdxW = $clog2(MarkW);
  localparam int unsigned CountW = 24;
  localparam int unsigned ColW = 4;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  typedef struct packed {
    logic [ColW-1:0] first_col;
    logic            whole;
  } in_word_t;

  typedef struct packed {
    logic [CountW-1:0] solution_count;
    logic              invalid;
  } out_word_t;

  typedef struct packed {
    logic             start;
    logic [SizeW-1:0] size;
    logic [RowW-1:0]  col;
  } eng_cmd_t;

  typedef struct packed {
    logic              done;
    logic [CountW-1:0] count;
  } eng_sts_t;

  typedef enum logic [3:0] {
    TopIdle   = 4'b0001,
    TopLaunch = 4'b0010,
    TopWait   = 4'b0100,
    TopFin    = 4'b1000
  } top_state_e;

  typedef enum logic [2:0] {
    EngIdle   = 3'b001,
    EngSearch = 3'b010,
    EngPop    = 3'b100
  } eng_state_e;

  // index of the lowest set bit, zero when none
  function automatic logic [RowW-1:0] lowest_bit(input logic [MaxSize-1:0] m);
    logic [RowW-1:0] idx;
    idx = '0;
    for (int i = MaxSize - 1; i >= 0; i--) begin
      if (m[i]) idx = RowW'(i);
    end
    return idx;
  endfunction

endpackage

// ===== hw/rtl/nqc_ram.sv =====
// generic single-port-write ram with registered read
module nqc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/nqc_engine.sv =====
// backtracking search over one first-row subtree, stack in ram
module nqc_engine
  import nqc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  eng_cmd_t cmd_i,
  output eng_sts_t sts_o
);

  eng_state_e          state_q, state_d;
  logic [MaxSize-1:0]  colm_q, colm_d;
  logic [MarkW-1:0]    rise_q, rise_d;
  logic [MarkW-1:0]    fall_q, fall_d;
  logic [RowW-1:0]     row_q, row_d;
  logic [CandW-1:0]    cand_q, cand_d;
  logic [SizeW-1:0]    n_q, n_d;
  logic [CountW-1:0]   sub_q, sub_d;
  logic                done_q, done_d;

  logic                we;
  logic [RowW-1:0]     raddr;
  logic [RowW-1:0]     rdata;
  logic [MaxSize-1:0]  busy, full, ge_mask, avail;
  logic [RowW-1:0]     low;
  logic [SizeW-1:0]    fall_sh;
  logic                tgl;
  logic [RowW-1:0]     tcol;
  logic [MarkIdxW:0]   rise_idx, fall_idx, init_fall_idx;
  logic [MaxSize:0]    full_w;

  nqc_ram #(
    .Width (RowW),
    .Depth (MaxSize)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (row_q),
    .wdata_i (low),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign fall_sh = n_q - SizeW'(1) - {1'b0, row_q};
  assign full_w  = ({{MaxSize{1'b0}}, 1'b1} << n_q) - {{MaxSize{1'b0}}, 1'b1};
  assign full    = full_w[MaxSize-1:0];
  assign busy    = colm_q | MaxSize'(rise_q >> row_q) | MaxSize'(fall_q >> fall_sh);
  assign ge_mask = {MaxSize{1'b1}} << cand_q;
  assign avail   = (cand_q < CandW'(n_q)) ? (~busy & full & ge_mask) : '0;
  assign low     = lowest_bit(avail);
  assign raddr   = row_q - RowW'(1);

  assign tcol     = (state_q == EngPop) ? rdata : low;
  assign rise_idx = (MarkIdxW + 1)'(tcol) + (MarkIdxW + 1)'(row_q);
  assign fall_idx = (MarkIdxW + 1)'(n_q) + (MarkIdxW + 1)'(tcol)
                    - (MarkIdxW + 1)'(1) - (MarkIdxW + 1)'(row_q);
  assign init_fall_idx = (MarkIdxW + 1)'(cmd_i.size) + (MarkIdxW + 1)'(cmd_i.col)
                         - (MarkIdxW + 1)'(1);

  always_comb begin
    state_d = state_q;
    colm_d  = colm_q;
    rise_d  = rise_q;
    fall_d  = fall_q;
    row_d   = row_q;
    cand_d  = cand_q;
    n_d     = n_q;
    sub_d   = sub_q;
    done_d  = 1'b0;
    we      = 1'b0;
    tgl     = 1'b0;
    unique case (state_q)
      EngIdle: begin
        if (cmd_i.start) begin
          n_d     = cmd_i.size;
          colm_d  = {{(MaxSize-1){1'b0}}, 1'b1} << cmd_i.col;
          rise_d  = {{(MarkW-1){1'b0}}, 1'b1} << cmd_i.col;
          fall_d  = {{(MarkW-1){1'b0}}, 1'b1} << init_fall_idx[MarkIdxW-1:0];
          row_d   = RowW'(1);
          cand_d  = '0;
          sub_d   = '0;
          state_d = EngSearch;
        end
      end
      EngSearch: begin
        if (avail != '0) begin
          if ({1'b0, row_q} == n_q - SizeW'(1)) begin
            if (sub_q != CountMax) sub_d = sub_q + CountW'(1);
            cand_d = CandW'(low) + CandW'(1);
          end else begin
            tgl    = 1'b1;
            we     = 1'b1;
            row_d  = row_q + RowW'(1);
            cand_d = '0;
          end
        end else if (row_q <= RowW'(1)) begin
          done_d  = 1'b1;
          state_d = EngIdle;
        end else begin
          row_d   = row_q - RowW'(1);
          state_d = EngPop;
        end
      end
      EngPop: begin
        tgl     = 1'b1;
        cand_d  = CandW'(rdata) + CandW'(1);
        state_d = EngSearch;
      end
      default: state_d = EngIdle;
    endcase
    if (tgl) begin
      colm_d = colm_q ^ ({{(MaxSize-1){1'b0}}, 1'b1} << tcol);
      rise_d = rise_q ^ ({{(MarkW-1){1'b0}}, 1'b1} << rise_idx[MarkIdxW-1:0]);
      fall_d = fall_q ^ ({{(MarkW-1){1'b0}}, 1'b1} << fall_idx[MarkIdxW-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= EngIdle;
      done_q  <= 1'b0;
      colm_q  <= '0;
      rise_q  <= '0;
      fall_q  <= '0;
      row_q   <= '0;
      sub_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      colm_q  <= colm_d;
      rise_q  <= rise_d;
      fall_q  <= fall_d;
      row_q   <= row_d;
      sub_q   <= sub_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q <= cand_d;
    n_q    <= n_d;
  end

  assign sts_o.done  = done_q;
  assign sts_o.count = sub_q;

endmodule

// ===== hw/rtl/nqueens_solution_counter_core.sv =====
// top level: query sequencing, mirror totals, size register and result register
// query time: set by the search steps and backtracks of the single search engine and its
//   stack ram read port; each first-row column after the first launches the engine again
// throughput: one query at a time; the next query is taken while a result waits
// reset: board size 8, engine idle, no result pending; the stack ram is never cleared
module nqueens_solution_counter_core
  import nqc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_word_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_word_t        out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [SizeW-1:0] cfg_data_i
);

  top_state_e        state_q, state_d;
  logic [SizeW-1:0]  size_q;
  logic [SizeW-1:0]  n_q, n_d;
  logic              whole_q, whole_d;
  logic              bad_q, bad_d;
  logic [ColW-1:0]   col_q, col_d;
  logic [CountW-1:0] total_q, total_d;
  logic              out_valid_q, out_valid_d;
  out_word_t         out_data_q, out_data_d;

  logic [SizeW-1:0]  size_use, half, nxt;
  logic              dbl, more;
  logic [CountW:0]   add;
  logic [CountW+1:0] sum;
  eng_cmd_t          cmd;
  eng_sts_t          sts;

  nqc_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

  always_comb begin
    if (size_q < SizeW'(MinSize)) size_use = SizeW'(MinSize);
    else if (size_q > SizeW'(MaxSize)) size_use = SizeW'(MaxSize);
    else size_use = size_q;
  end

  assign half = n_q >> 1;
  assign nxt  = SizeW'(col_q) + SizeW'(1);
  assign dbl  = whole_q && (SizeW'(col_q) < half);
  assign more = whole_q && ((nxt < half) || (n_q[0] && (nxt == half)));
  assign add  = dbl ? {sts.count, 1'b0} : {1'b0, sts.count};
  assign sum  = {2'b00, total_q} + {1'b0, add};

  assign cmd.start = (state_q == TopLaunch);
  assign cmd.size  = n_q;
  assign cmd.col   = col_q;

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    whole_d     = whole_q;
    bad_d       = bad_q;
    col_d       = col_q;
    total_d     = total_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    unique case (state_q)
      TopIdle: begin
        if (in_valid_i) begin
          n_d     = size_use;
          whole_d = in_data_i.whole;
          col_d   = in_data_i.whole ? '0 : in_data_i.first_col;
          total_d = '0;
          bad_d   = !in_data_i.whole && (SizeW'(in_data_i.first_col) >= size_use);
          state_d = bad_d ? TopFin : TopLaunch;
        end
      end
      TopLaunch: state_d = TopWait;
      TopWait: begin
        if (sts.done) begin
          total_d = (sum[CountW+1:CountW] != 2'b00) ? CountMax : sum[CountW-1:0];
          if (more) begin
            col_d   = nxt[ColW-1:0];
            state_d = TopLaunch;
          end else begin
            state_d = TopFin;
          end
        end
      end
      TopFin: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d                = 1'b1;
          out_data_d.solution_count  = total_q;
          out_data_d.invalid         = bad_q;
          state_d                    = TopIdle;
        end
      end
      default: state_d = TopIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= TopIdle;
      out_valid_q <= 1'b0;
      size_q      <= SizeW'(ResetSize);
      n_q         <= SizeW'(ResetSize);
      whole_q     <= 1'b0;
      bad_q       <= 1'b0;
      col_q       <= '0;
      total_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      n_q         <= n_d;
      whole_q     <= whole_d;
      bad_q       <= bad_d;
      col_q       <= col_d;
      total_q     <= total_d;
      if (cfg_valid_i) begin
        size_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign in_ready_o  = (state_q == TopIdle);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
